// ===== rtl/rcfs_pkg.sv =====
// shared types, constants and sync pattern for the rc frame sync channel mapper
package rcfs_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int CHANNELS_DEF    = 10;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int RAW_W   = 16;
  localparam int ANGLE_W = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 8'd1;

  localparam logic [BYTE_W-1:0] MIN_ANGLE_RST = 8'd0;
  localparam logic [BYTE_W-1:0] MAX_ANGLE_RST = 8'd180;

  localparam int SYNC_POS_A = 0;
  localparam int SYNC_POS_B = 1;
  localparam int SYNC_POS_C = 28;
  localparam int SYNC_POS_D = 29;
  localparam int CHAN_POS   = 2;

  localparam logic [BYTE_W-1:0] SYNC_A = 8'h20;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'h40;
  localparam logic [BYTE_W-1:0] SYNC_C = 8'hDC;
  localparam logic [BYTE_W-1:0] SYNC_D = 8'h05;

  localparam int OFF_W  = RAW_W + 1;
  localparam int SPAN_W = BYTE_W + 1;
  localparam int PROD_W = OFF_W + SPAN_W;
  localparam int MAG_W  = 24;
  localparam int RECIP_W = 25;
  localparam int RECIP_SHIFT = 34;
  localparam int QUOT_W = MAG_W + RECIP_W - RECIP_SHIFT;

  localparam logic signed [OFF_W-1:0] IN_LOW = 17'sd1000;
  // ceil(2^34 / 1000), exact truncating division by 1000 for 24-bit magnitudes
  localparam logic [RECIP_W-1:0] RECIP = 25'd17179870;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] raw;
    logic             last;
  } chan_t;

endpackage

// ===== rtl/rcfs_angle_map.sv =====
// three-stage pipeline mapping a raw channel value onto the configured angle range
module rcfs_angle_map (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rcfs_pkg::chan_t                     in_chan,
  input  logic [rcfs_pkg::BYTE_W-1:0]         min_angle,
  input  logic [rcfs_pkg::BYTE_W-1:0]         max_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rcfs_pkg::chan_t                     out_chan,
  output logic signed [rcfs_pkg::ANGLE_W-1:0] out_angle
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  rcfs_pkg::chan_t c1, c2;
  logic signed [rcfs_pkg::PROD_W-1:0] p1;
  logic [rcfs_pkg::MAG_W+rcfs_pkg::RECIP_W-1:0] prod2;
  logic neg2;

  logic signed [rcfs_pkg::OFF_W-1:0]  off;
  logic signed [rcfs_pkg::SPAN_W-1:0] span;
  logic signed [rcfs_pkg::PROD_W-1:0] p_next;
  logic [rcfs_pkg::PROD_W-1:0]        mag_full;
  logic [rcfs_pkg::MAG_W-1:0]         mag;
  logic [rcfs_pkg::QUOT_W-1:0]        quot;
  logic signed [rcfs_pkg::ANGLE_W-1:0] q_ext;
  logic signed [rcfs_pkg::ANGLE_W-1:0] q_signed;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v3;

  // stage 1: offset times span
  assign off    = $signed({1'b0, in_chan.raw}) - rcfs_pkg::IN_LOW;
  assign span   = $signed({1'b0, max_angle}) - $signed({1'b0, min_angle});
  assign p_next = rcfs_pkg::PROD_W'(off) * rcfs_pkg::PROD_W'(span);

  // stage 2: magnitude times reciprocal of 1000
  assign mag_full = p1[rcfs_pkg::PROD_W-1] ? rcfs_pkg::PROD_W'(-p1) : rcfs_pkg::PROD_W'(p1);
  assign mag      = mag_full[rcfs_pkg::MAG_W-1:0];

  // stage 3: restore sign, add offset angle
  assign quot     = prod2[rcfs_pkg::RECIP_SHIFT +: rcfs_pkg::QUOT_W];
  assign q_ext    = $signed(rcfs_pkg::ANGLE_W'(quot));
  assign q_signed = neg2 ? -q_ext : q_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c1 <= in_chan;
      p1 <= p_next;
    end
    if (adv2) begin
      c2    <= c1;
      neg2  <= p1[rcfs_pkg::PROD_W-1];
      prod2 <= (rcfs_pkg::MAG_W+rcfs_pkg::RECIP_W)'(mag)
             * (rcfs_pkg::MAG_W+rcfs_pkg::RECIP_W)'(rcfs_pkg::RECIP);
    end
    if (adv3) begin
      out_chan  <= c2;
      out_angle <= q_signed + $signed({8'b0, min_angle});
    end
  end

endmodule

// ===== rtl/rc_frame_sync_channel_mapper_core.sv =====
// top level: byte window, sync detection, frame capture and channel sequencing
// channel 0 of a completed frame is registered in the frame capture, then in each mapping stage
// throughput: one byte request per cycle and one result per cycle while out_ready is high
// a byte that completes a frame waits while the previous frame still has channels to issue
// reset clears the byte window, the sequencer and the mapping pipeline; angles return to 0..180
module rc_frame_sync_channel_mapper_core #(
  parameter int FRAME_BYTES = rcfs_pkg::FRAME_BYTES_DEF,
  parameter int CHANNELS    = rcfs_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rcfs_pkg::BYTE_W-1:0]         rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rcfs_pkg::IDX_W-1:0]          channel_index,
  output logic [rcfs_pkg::RAW_W-1:0]          raw_value,
  output logic signed [rcfs_pkg::ANGLE_W-1:0] angle,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcfs_pkg::BYTE_W-1:0]         cfg_data
);

  logic [rcfs_pkg::BYTE_W-1:0] win      [FRAME_BYTES];
  logic [rcfs_pkg::BYTE_W-1:0] win_next [FRAME_BYTES];
  logic [rcfs_pkg::RAW_W-1:0]  frame      [CHANNELS];
  logic [rcfs_pkg::RAW_W-1:0]  frame_next [CHANNELS];

  logic [rcfs_pkg::BYTE_W-1:0] min_angle, max_angle;
  logic [rcfs_pkg::IDX_W-1:0]  cnt;
  logic busy;
  logic sync_next, accept, load, load_ok, issue, issue_last;
  logic map_ready;
  rcfs_pkg::chan_t issue_chan, out_chan;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle <= rcfs_pkg::MIN_ANGLE_RST;
      max_angle <= rcfs_pkg::MAX_ANGLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rcfs_pkg::REG_MIN_ANGLE) min_angle <= cfg_data;
      if (cfg_index == rcfs_pkg::REG_MAX_ANGLE) max_angle <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) win_next[i] = win[i+1];
    win_next[FRAME_BYTES-1] = rx_byte;
    for (int k = 0; k < CHANNELS; k++) begin
      frame_next[k] = {win_next[rcfs_pkg::CHAN_POS+2*k+1], win_next[rcfs_pkg::CHAN_POS+2*k]};
    end
  end

  assign sync_next = (win_next[rcfs_pkg::SYNC_POS_A] == rcfs_pkg::SYNC_A)
                  && (win_next[rcfs_pkg::SYNC_POS_B] == rcfs_pkg::SYNC_B)
                  && (win_next[rcfs_pkg::SYNC_POS_C] == rcfs_pkg::SYNC_C)
                  && (win_next[rcfs_pkg::SYNC_POS_D] == rcfs_pkg::SYNC_D);

  assign issue_chan.idx  = cnt;
  assign issue_chan.raw  = frame[0];
  assign issue_chan.last = (cnt == rcfs_pkg::IDX_W'(CHANNELS - 1));

  assign issue      = busy && map_ready;
  assign issue_last = issue && issue_chan.last;
  assign load_ok    = !busy || issue_last;
  assign in_ready   = !sync_next || load_ok;
  assign accept     = in_valid && in_ready;
  assign load       = accept && sync_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_BYTES; i++) win[i] <= '0;
    end else if (accept) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (issue) begin
      if (issue_chan.last) busy <= 1'b0;
      cnt <= cnt + 1'b1;
    end
  end

  // the captured frame shifts on each issue, so the channel to issue next always sits at the head
  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_next;
    end else if (issue) begin
      for (int k = 0; k < CHANNELS - 1; k++) frame[k] <= frame[k+1];
    end
  end

  rcfs_angle_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (busy),
    .in_ready  (map_ready),
    .in_chan   (issue_chan),
    .min_angle (min_angle),
    .max_angle (max_angle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_chan  (out_chan),
    .out_angle (angle)
  );

  assign channel_index = out_chan.idx;
  assign raw_value     = out_chan.raw;
  assign last          = out_chan.last;

endmodule

// ===== rtl/rcfs_checker.sv =====
// port-level checker for the rc frame sync channel mapper, bound to the top level
module rcfs_checker #(
  parameter int CHANNELS = rcfs_pkg::CHANNELS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rcfs_pkg::IDX_W-1:0]          channel_index,
  input logic [rcfs_pkg::RAW_W-1:0]          raw_value,
  input logic signed [rcfs_pkg::ANGLE_W-1:0] angle,
  input logic                                last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_next_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && channel_index == $past(channel_index) + 1'b1)
    else $error("channels of a frame not delivered back to back in order");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || channel_index == '0)
    else $error("new frame does not start at channel 0");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> channel_index == rcfs_pkg::IDX_W'(CHANNELS - 1))
    else $error("last flag on wrong channel");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(channel_index) && $stable(raw_value) && $stable(angle)
      && $stable(last))
    else $error("stalled result changed");

endmodule

bind rc_frame_sync_channel_mapper_core rcfs_checker #(.CHANNELS(CHANNELS)) u_rcfs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_index (channel_index),
  .raw_value     (raw_value),
  .angle         (angle),
  .last          (last)
);
